### hdl/sorted_set_table_core_macros.svh
// Assertion macros for the sorted set table core.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef SORTED_SET_TABLE_CORE_MACROS_SVH
`define SORTED_SET_TABLE_CORE_MACROS_SVH

// Condition must never hold outside reset.
`define SST_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sst_pkg.sv
// Shared types and codes for the sorted set table core.
// No dependencies.
`default_nettype none

package sst_pkg;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_DELETE = 2'd1;
	localparam op_t OP_SEARCH = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_MISS = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_SHUP   = 7'b0001000,
		S_SHDN   = 7'b0010000,
		S_WRKEY  = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

### hdl/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/sorted_set_table_core.sv
// Sorted set table core: ordered set of distinct signed words with insert/delete/search.
// Depends on sst_pkg, sst_ram and sorted_set_table_core_macros.svh.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid, in_ready, func, key_value             | in
//   out     | out_valid, out_ready, status, position,         | out
//           | element_count, smallest_value                   |
//
// One request at a time. A request runs through the accept, a linear scan of the RAM (one
// entry per cycle, stops at the first entry not below the key), a decide state, a shift of
// the entries above the position (one RAM read and one write per cycle), the key write and
// a finish state. An insert into the middle is the worst case. The single RAM read/write
// port pair and the one shared comparator set this pace.
// Reset clears the count and the output valid; RAM contents are never cleared,
// only the first count entries are read. A result waits in the output register
// while the next request is taken; the finish cycle stalls only if it is still full.
`default_nettype none

module sorted_set_table_core #(
	parameter int CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sst_pkg::op_t          func,
	input  logic signed [31:0]    key_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sst_pkg::status_t      status,
	output logic [6:0]            position,
	output logic [6:0]            element_count,
	output logic signed [31:0]    smallest_value
);

	import sst_pkg::*;

	`include "sorted_set_table_core_macros.svh"

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t             state_q;
	op_t                op_q;
	logic signed [31:0] key_q;
	logic [AW-1:0]      idx_q;    // scan index of the entry on rd_data
	logic [AW-1:0]      sh_q;     // shift index of the entry on rd_data
	logic [CW-1:0]      pos_q;
	logic               found_q;
	status_t            status_q;
	logic [CW-1:0]      count_q;
	logic [31:0]        min_q;    // mirror of entry 0

	logic               out_valid_q;
	status_t            out_status_q;
	logic [6:0]         out_pos_q;
	logic [6:0]         out_count_q;
	logic [31:0]        out_min_q;

	// RAM port signals
	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic [AW-1:0]      raddr;
	logic [31:0]        rd_data;

	// shared compare unit and index helpers
	logic               key_gt;   // held entry below key
	logic               key_eq;
	logic [CW-1:0]      idx_inc;
	logic               full;

	// terms for the checks
	logic               take_empty;
	logic               count_upd;
	logic               wr_allowed;

	assign key_gt  = $signed(rd_data) < key_q;
	assign key_eq  = rd_data == key_q;
	assign idx_inc = CW'(idx_q) + CW'(1);
	assign full    = count_q == CW'(CAPACITY);

	sst_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// Read address: each state fetches the entry the next cycle works on.
	always_comb begin
		raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				raddr = '0;
			end
			S_SCAN: begin
				raddr = AW'(idx_inc);
			end
			S_DECIDE: begin
				if (op_q == OP_INSERT) begin
					raddr = AW'(count_q - CW'(1));
				end else begin
					raddr = AW'(pos_q + CW'(1));
				end
			end
			S_SHUP: begin
				raddr = sh_q - AW'(1);
			end
			S_SHDN: begin
				raddr = sh_q + AW'(1);
			end
			S_WRKEY, S_FIN: begin
				raddr = '0;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// Write port: shifts move rd_data one slot, then the key lands at pos.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rd_data;
		unique case (state_q)
			S_SHUP: begin
				we    = 1'b1;
				waddr = sh_q + AW'(1);
			end
			S_SHDN: begin
				we    = 1'b1;
				waddr = sh_q - AW'(1);
			end
			S_WRKEY: begin
				we    = 1'b1;
				waddr = AW'(pos_q);
				wdata = key_q;
			end
			S_IDLE, S_SCAN, S_DECIDE, S_FIN: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			min_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the finish state owns out_valid_q while it runs
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q  <= func;
						key_q <= key_value;
						idx_q <= '0;
						if (count_q == '0) begin
							// empty set: nothing to scan
							pos_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (key_gt) begin
						idx_q <= AW'(idx_inc);
						if (idx_inc == count_q) begin
							pos_q   <= count_q;
							found_q <= 1'b0;
							state_q <= S_DECIDE;
						end
					end else begin
						pos_q   <= CW'(idx_q);
						found_q <= key_eq;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (op_q)
						OP_INSERT: begin
							if (found_q) begin
								status_q <= ST_MISS;
								state_q  <= S_FIN;
							end else if (full) begin
								status_q <= ST_FULL;
								state_q  <= S_FIN;
							end else begin
								status_q <= ST_OK;
								if (pos_q == count_q) begin
									state_q <= S_WRKEY;
								end else begin
									sh_q    <= AW'(count_q - CW'(1));
									state_q <= S_SHUP;
								end
							end
						end
						OP_DELETE: begin
							if (found_q) begin
								status_q <= ST_OK;
								if (pos_q + CW'(1) == count_q) begin
									count_q <= count_q - CW'(1);
									state_q <= S_FIN;
								end else begin
									sh_q    <= AW'(pos_q + CW'(1));
									state_q <= S_SHDN;
								end
							end else begin
								status_q <= ST_MISS;
								state_q  <= S_FIN;
							end
						end
						default: begin
							// search, and the unused code behaves as search
							status_q <= found_q ? ST_OK : ST_MISS;
							state_q  <= S_FIN;
						end
					endcase
				end
				S_SHUP: begin
					if (CW'(sh_q) == pos_q) begin
						state_q <= S_WRKEY;
					end else begin
						sh_q <= sh_q - AW'(1);
					end
				end
				S_SHDN: begin
					if (CW'(sh_q) + CW'(1) == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end else begin
						sh_q <= sh_q + AW'(1);
					end
				end
				S_WRKEY: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_pos_q    <= 7'(pos_q);
						out_count_q  <= 7'(count_q);
						out_min_q    <= (count_q == '0) ? 32'd0 : min_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = state_q == S_IDLE;
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign position       = out_pos_q;
	assign element_count  = out_count_q;
	assign smallest_value = out_min_q;

	// checks
	assign take_empty = in_valid && in_ready && (count_q == '0);
	assign count_upd  = (state_q == S_WRKEY) || (state_q == S_DECIDE) || (state_q == S_SHDN);
	assign wr_allowed = (state_q == S_SHUP) || (state_q == S_SHDN) || (state_q == S_WRKEY);

	`SST_ASSERT_NEVER(a_count_bound, count_q > CW'(CAPACITY), "entry count above capacity")
	`SST_ASSERT_NEXT(a_empty_skip, take_empty, state_q == S_DECIDE, "empty set entered scan")
	`SST_ASSERT_NEXT(a_count_hold, !count_upd, $stable(count_q), "count changed outside update")
	`SST_ASSERT_NEVER(a_write_busy, we && !wr_allowed, "RAM write outside shift or key write")

endmodule

`default_nettype wire
